@@ hdl/rgb565_box_downsample_2x2_macros.svh @@
// Assertion macros for the 2x2 box downsampler.
// Both macros sample on aclk and are disabled while aresetn is low.
`ifndef RGB565_BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define RGB565_BOX_DOWNSAMPLE_2X2_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define RBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBD_ASSERT_NOW(lbl, ante, cons, msg)
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/rbd_pkg.sv @@
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int PIX_W  = 16;
    localparam int SUM_W  = 19;
    localparam int CFG_SW_W = 11;
    localparam int CFG_SH_W = 11;
    localparam int CFG_OW_W = 10;
    localparam int CFG_OH_W = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_SW_W-1:0] RST_SOURCE_WIDTH  = 11'd640;
    localparam logic [CFG_SH_W-1:0] RST_SOURCE_HEIGHT = 11'd480;
    localparam logic [CFG_OW_W-1:0] RST_OUTPUT_WIDTH  = 10'd320;
    localparam logic [CFG_OH_W-1:0] RST_OUTPUT_HEIGHT = 10'd240;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_OUTPUT_WIDTH  = 2'd2,
        CFG_OUTPUT_HEIGHT = 2'd3
    } cfg_index_e;

    typedef logic [PIX_W-1:0] pixel_t;
    // red sum 18..13, green sum 12..6, blue sum 5..0
    typedef logic [SUM_W-1:0] pair_sum_t;

    typedef struct packed {
        logic [CFG_SW_W-1:0] source_width;
        logic [CFG_SH_W-1:0] source_height;
        logic [CFG_OW_W-1:0] output_width;
        logic [CFG_OH_W-1:0] output_height;
    } cfg_t;

    // Pending odd-row odd-column item waiting for its line store read.
    typedef struct packed {
        pair_sum_t ps;
        logic      last;
    } issue_t;

    function automatic pair_sum_t pair_sum(input pixel_t a, input pixel_t b);
        logic [5:0] r;
        logic [6:0] g;
        logic [5:0] bl;
        r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
        g  = {1'b0, a[10:5]}  + {1'b0, b[10:5]};
        bl = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
        return {r, g, bl};
    endfunction

    // Four-pixel average from two pair sums, truncated.
    function automatic pixel_t box_avg(input pair_sum_t st, input pair_sum_t ps);
        logic [6:0] r;
        logic [7:0] g;
        logic [6:0] bl;
        r  = {1'b0, st[18:13]} + {1'b0, ps[18:13]};
        g  = {1'b0, st[12:6]}  + {1'b0, ps[12:6]};
        bl = {1'b0, st[5:0]}   + {1'b0, ps[5:0]};
        return {r[6:2], g[7:2], bl[6:2]};
    endfunction

endpackage

@@ hdl/rbd_ram.sv @@
`timescale 1ns / 1ps

module rbd_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 512
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/rbd_ctrl.sv @@
`timescale 1ns / 1ps

module rbd_ctrl #(
    parameter int MAX_SOURCE_WIDTH  = 1024,
    parameter int MAX_SOURCE_HEIGHT = 1024,
    parameter int AW                = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rbd_pkg::cfg_t      cfg,
    input  logic               accept,
    input  rbd_pkg::pixel_t    pixel,
    output logic               wr_en,
    output logic               rd_en,
    output logic [AW-1:0]      line_addr,
    output rbd_pkg::pair_sum_t wr_data,
    output rbd_pkg::issue_t    issue
);

    localparam int CW   = $clog2(MAX_SOURCE_WIDTH);
    localparam int RW   = $clog2(MAX_SOURCE_HEIGHT);
    localparam int EWW0 = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int EHW0 = $clog2(MAX_SOURCE_HEIGHT + 1);
    localparam int EWW  = (EWW0 > rbd_pkg::CFG_SW_W) ? EWW0 : rbd_pkg::CFG_SW_W;
    localparam int EHW  = (EHW0 > rbd_pkg::CFG_SH_W) ? EHW0 : rbd_pkg::CFG_SH_W;

    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    rbd_pkg::pixel_t first_reg, first_next;

    logic [EWW-1:0] sw_x, sw_e, ow_x, ow_e, half_w, c_x, c_n, col_half;
    logic [EHW-1:0] sh_x, sh_e, oh_x, oh_e, half_h, r_x, r_n, row_half;
    logic           in_win;
    rbd_pkg::pair_sum_t ps;

    // Effective sizes, saturated as the config ranges require.
    always_comb begin
        sw_x = EWW'(cfg.source_width);
        sh_x = EHW'(cfg.source_height);
        if (sw_x < EWW'(2))                     sw_e = EWW'(2);
        else if (sw_x > EWW'(MAX_SOURCE_WIDTH)) sw_e = EWW'(MAX_SOURCE_WIDTH);
        else                                    sw_e = sw_x;
        if (sh_x < EHW'(2))                      sh_e = EHW'(2);
        else if (sh_x > EHW'(MAX_SOURCE_HEIGHT)) sh_e = EHW'(MAX_SOURCE_HEIGHT);
        else                                     sh_e = sh_x;
        half_w = sw_e >> 1;
        half_h = sh_e >> 1;
        ow_x   = EWW'(cfg.output_width);
        oh_x   = EHW'(cfg.output_height);
        if (ow_x == '0)          ow_e = EWW'(1);
        else if (ow_x > half_w)  ow_e = half_w;
        else                     ow_e = ow_x;
        if (oh_x == '0)          oh_e = EHW'(1);
        else if (oh_x > half_h)  oh_e = half_h;
        else                     oh_e = oh_x;
    end

    // Position of this beat (wrap first if the size shrank), then advance.
    always_comb begin
        c_x = EWW'(col_reg);
        r_x = EHW'(row_reg);
        if (c_x >= sw_e) begin
            c_x = '0;
            r_x = r_x + EHW'(1);
        end
        if (r_x >= sh_e) begin
            r_x = '0;
        end
        col_half = c_x >> 1;
        row_half = r_x >> 1;
        in_win   = (col_half < ow_e) && (row_half < oh_e);

        c_n = c_x + EWW'(1);
        r_n = r_x;
        if (c_n >= sw_e) begin
            c_n = '0;
            r_n = r_x + EHW'(1);
            if (r_n >= sh_e) begin
                r_n = '0;
            end
        end
    end

    assign ps = rbd_pkg::pair_sum(first_reg, pixel);

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        first_next = first_reg;
        if (accept) begin
            col_next = c_n[CW-1:0];
            row_next = r_n[RW-1:0];
            if (in_win && !c_x[0]) begin
                first_next = pixel;
            end
        end
    end

    assign wr_en      = accept && in_win && c_x[0] && !r_x[0];
    assign rd_en      = accept && in_win && c_x[0] && r_x[0];
    assign line_addr  = col_half[AW-1:0];
    assign wr_data    = ps;
    assign issue.ps   = ps;
    assign issue.last = (col_half == ow_e - EWW'(1)) && (row_half == oh_e - EHW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            first_reg <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            first_reg <= first_next;
        end
    end

endmodule

@@ hdl/rbd_merge.sv @@
`timescale 1ns / 1ps

module rbd_merge (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               issue_valid,
    input  rbd_pkg::issue_t    issue,
    input  rbd_pkg::pair_sum_t rd_data,
    input  logic               m_tready,
    output logic               ready,
    output logic               s1_valid,
    output logic               m_tvalid,
    output rbd_pkg::pixel_t    m_tdata,
    output logic               m_tlast
);

    logic            s1_valid_reg, s1_valid_next;
    rbd_pkg::issue_t s1_reg, s1_next;
    logic            m_valid_reg, m_valid_next;
    rbd_pkg::pixel_t m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;
    logic            advance;

    // Line store data stays put while stalled: its read only fires on issue.
    assign advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign ready   = !s1_valid_reg || advance;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        if (advance) begin
            m_valid_next  = 1'b1;
            m_data_next   = rbd_pkg::box_avg(rd_data, s1_reg.ps);
            m_last_next   = s1_reg.last;
            s1_valid_next = 1'b0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (issue_valid) begin
            s1_valid_next = 1'b1;
            s1_next       = issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        s1_reg     <= s1_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign s1_valid = s1_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ hdl/rgb565_box_downsample_2x2.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents
// s_*       in   16     tdata: source_pixel[15:0] (RGB565)
// m_*       out  16+1   tdata: output_pixel[15:0]; tlast: last_of_frame
// cfg_wr_*  in   2+11   index 0..3: source_width, source_height, output_width, output_height
//
// Takes one source beat per cycle unless m_tready stalls the pipe; at most
// one line store access per beat. An odd-row odd-column source beat reaches
// its output beat through the line store read, then the output register.
// Synchronous active-low reset clears positions, pair register and valids;
// the line store has no clear, every entry is written on an even row first.
// m_tready low stalls the output register, then the read stage, then s_tready.

`include "rgb565_box_downsample_2x2_macros.svh"

module rgb565_box_downsample_2x2 #(
    parameter int MAX_SOURCE_WIDTH  = 1024,
    parameter int MAX_SOURCE_HEIGHT = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // source beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [15:0] source_pixel
    // output beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [15:0] output_pixel
    output logic                               m_tlast,   // last_of_frame
    // config writes
    input  logic                               cfg_wr_en,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    // One line store entry per source column pair.
    localparam int LINE_DEPTH = MAX_SOURCE_WIDTH / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    rbd_pkg::cfg_t      cfg_reg, cfg_next;
    logic               accept;
    logic               wr_en, rd_en;
    logic [AW-1:0]      line_addr;
    rbd_pkg::pair_sum_t wr_data, rd_data;
    rbd_pkg::issue_t    issue;
    logic               merge_ready;
    logic               s1_valid;

    // Config registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (rbd_pkg::cfg_index_e'(cfg_wr_index))
                rbd_pkg::CFG_SOURCE_WIDTH: begin
                    cfg_next.source_width = cfg_wr_data[rbd_pkg::CFG_SW_W-1:0];
                end
                rbd_pkg::CFG_SOURCE_HEIGHT: begin
                    cfg_next.source_height = cfg_wr_data[rbd_pkg::CFG_SH_W-1:0];
                end
                rbd_pkg::CFG_OUTPUT_WIDTH: begin
                    cfg_next.output_width = cfg_wr_data[rbd_pkg::CFG_OW_W-1:0];
                end
                rbd_pkg::CFG_OUTPUT_HEIGHT: begin
                    cfg_next.output_height = cfg_wr_data[rbd_pkg::CFG_OH_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_width  <= rbd_pkg::RST_SOURCE_WIDTH;
            cfg_reg.source_height <= rbd_pkg::RST_SOURCE_HEIGHT;
            cfg_reg.output_width  <= rbd_pkg::RST_OUTPUT_WIDTH;
            cfg_reg.output_height <= rbd_pkg::RST_OUTPUT_HEIGHT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Source side: a beat is taken whenever the read stage can move on.
    assign s_tready = merge_ready;
    assign accept   = s_tvalid && s_tready;

    // Position tracking, pair sum, line store addressing
    rbd_ctrl #(
        .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
        .AW                (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .accept    (accept),
        .pixel     (s_tdata),
        .wr_en     (wr_en),
        .rd_en     (rd_en),
        .line_addr (line_addr),
        .wr_data   (wr_data),
        .issue     (issue)
    );

    // Even-row pair sums, one per output column. Write and read never share a
    // beat, and a read follows its write by at least one row, so no forwarding.
    rbd_ram #(
        .WIDTH (rbd_pkg::SUM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (line_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (line_addr),
        .rd_data (rd_data)
    );

    // Vertical add, average, output register
    rbd_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue_valid (rd_en),
        .issue       (issue),
        .rd_data     (rd_data),
        .m_tready    (m_tready),
        .ready       (merge_ready),
        .s1_valid    (s1_valid),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    `RBD_ASSERT_NOW(a_no_rw_same_beat, wr_en, !rd_en, "line store read and write in one beat")
    `RBD_ASSERT_NEXT(a_read_lands, rd_en, s1_valid, "line store read lost")
    `RBD_ASSERT_NOW(a_stall_cause, !s_tready, s1_valid && m_tvalid && !m_tready, "spurious stall")

endmodule

@@ tb/tb_rgb565_box_downsample_2x2.sv @@
`timescale 1ns / 1ps

module tb_rgb565_box_downsample_2x2;

    // generous bound on the whole run, several times the slowest legal run
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned LINE_ENTRIES = 512;
    localparam int unsigned MAX_SRC      = 1024;
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef struct {
        rbd_pkg::pixel_t pixel;
        logic            last;
    } out_beat_t;

    // Predicts the averaged output beats from the accepted source beats.
    class downsample_scoreboard;
        logic [rbd_pkg::CFG_SW_W-1:0] src_w_reg;
        logic [rbd_pkg::CFG_SH_W-1:0] src_h_reg;
        logic [rbd_pkg::CFG_OW_W-1:0] out_w_reg;
        logic [rbd_pkg::CFG_OH_W-1:0] out_h_reg;
        int unsigned                  col;
        int unsigned                  row;
        rbd_pkg::pixel_t              held_pixel;
        rbd_pkg::pair_sum_t           pair_store [LINE_ENTRIES];
        out_beat_t                    averaged_pixels_q [$];
        int unsigned                  error_count;

        function new();
            src_w_reg   = rbd_pkg::RST_SOURCE_WIDTH;
            src_h_reg   = rbd_pkg::RST_SOURCE_HEIGHT;
            out_w_reg   = rbd_pkg::RST_OUTPUT_WIDTH;
            out_h_reg   = rbd_pkg::RST_OUTPUT_HEIGHT;
            col         = 0;
            row         = 0;
            held_pixel  = '0;
            error_count = 0;
            foreach (pair_store[i]) pair_store[i] = '0;
        endfunction

        function void write_reg(rbd_pkg::cfg_index_e idx,
                                logic [rbd_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                rbd_pkg::CFG_SOURCE_WIDTH:  src_w_reg = value;
                rbd_pkg::CFG_SOURCE_HEIGHT: src_h_reg = value;
                rbd_pkg::CFG_OUTPUT_WIDTH:  out_w_reg = value[rbd_pkg::CFG_OW_W-1:0];
                rbd_pkg::CFG_OUTPUT_HEIGHT: out_h_reg = value[rbd_pkg::CFG_OH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void eff_sizes(output int unsigned sw, output int unsigned sh,
                                output int unsigned ow, output int unsigned oh);
            sw = clamp(32'(src_w_reg), 2, MAX_SRC);
            sh = clamp(32'(src_h_reg), 2, MAX_SRC);
            ow = clamp(32'(out_w_reg), 1, sw / 2);
            oh = clamp(32'(out_h_reg), 1, sh / 2);
        endfunction

        function int unsigned frame_pixel_count();
            int unsigned sw, sh, ow, oh;
            eff_sizes(sw, sh, ow, oh);
            return sw * sh;
        endfunction

        function int unsigned pending_count();
            return averaged_pixels_q.size();
        endfunction

        function void accept_source_pixel(rbd_pkg::pixel_t px);
            int unsigned        sw, sh, ow, oh;
            logic [5:0]         rp, bp;
            logic [6:0]         gp;
            logic [7:0]         rs, gs, bs;
            rbd_pkg::pair_sum_t ps, st;
            out_beat_t          beat;
            eff_sizes(sw, sh, ow, oh);
            if (col >= sw) begin
                col = 0;
                row++;
            end
            if (row >= sh) row = 0;
            if (col < 2 * ow && row < 2 * oh) begin
                if (col % 2 == 0) begin
                    held_pixel = px;
                end else begin
                    rp = 6'(held_pixel[15:11]) + 6'(px[15:11]);
                    gp = 7'(held_pixel[10:5])  + 7'(px[10:5]);
                    bp = 6'(held_pixel[4:0])   + 6'(px[4:0]);
                    ps = {rp, gp, bp};
                    if (row % 2 == 0) begin
                        pair_store[9'(col / 2)] = ps;
                    end else begin
                        st = pair_store[9'(col / 2)];
                        rs = 8'(st[18:13]) + 8'(rp);
                        gs = 8'(st[12:6])  + 8'(gp);
                        bs = 8'(st[5:0])   + 8'(bp);
                        beat.pixel = {rs[6:2], gs[7:2], bs[6:2]};
                        beat.last  = (col / 2 == ow - 1) && (row / 2 == oh - 1);
                        averaged_pixels_q.push_back(beat);
                    end
                end
            end
            col = col + 1;
            if (col >= sw) begin
                col = 0;
                row = row + 1;
                if (row >= sh) row = 0;
            end
        endfunction

        function void check_output_beat(rbd_pkg::pixel_t px, logic last);
            out_beat_t exp_beat;
            if (averaged_pixels_q.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("mismatch: unexpected output beat pixel %h last %b", px, last);
                return;
            end
            exp_beat = averaged_pixels_q.pop_front();
            if (px !== exp_beat.pixel || last !== exp_beat.last) begin
                error_count++;
                if (error_count <= 10)
                    $display("mismatch: expected pixel %h last %b, got pixel %h last %b",
                             exp_beat.pixel, exp_beat.last, px, last);
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;   // [15:0] source_pixel
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;   // [15:0] output_pixel
    logic                           m_tlast;   // last_of_frame
    logic                           cfg_wr_en;
    logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_wr_index;
    logic [rbd_pkg::CFG_DATA_W-1:0] cfg_wr_data;

    downsample_scoreboard sb;

    int unsigned     cycle_count;
    bit              sink_no_stall;
    bit              src_burst;
    int unsigned     phase_no;
    int unsigned     random_sent;
    int unsigned     pix_total;
    int unsigned     frames;
    int              hold_at;
    logic [10:0]     sw_raw, sh_raw;
    logic [9:0]      ow_raw, oh_raw;
    rbd_pkg::pixel_t directed_pixels [20];

    rgb565_box_downsample_2x2 dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output side: before every beat, hold m_tready low for a random stall,
    // then keep it high until a beat is taken. Stalls also fall while nothing
    // is pending, so back-pressure hits every stage of the pipe.
    initial begin : sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = sink_no_stall ? 0 : $urandom_range(0, 14);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_output_beat(m_tdata, m_tlast);
        end
    end

    function automatic int unsigned draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    // one register write, seen by the block at the next rising edge
    task automatic write_config(input rbd_pkg::cfg_index_e idx,
                                input logic [rbd_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_sizes(input logic [10:0] sw, input logic [10:0] sh,
                               input logic [9:0] ow, input logic [9:0] oh);
        write_config(rbd_pkg::CFG_SOURCE_WIDTH, sw);
        write_config(rbd_pkg::CFG_SOURCE_HEIGHT, sh);
        write_config(rbd_pkg::CFG_OUTPUT_WIDTH, {1'b0, ow});
        write_config(rbd_pkg::CFG_OUTPUT_HEIGHT, {1'b0, oh});
    endtask

    // Source beat: idle for gap cycles, then present the pixel until taken.
    // With gap 0 tvalid just stays high from the previous beat.
    task automatic send_pixel(input rbd_pkg::pixel_t px, input int unsigned gap);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.accept_source_pixel(px);
    endtask

    // drop tvalid, drain every pending beat, then let the pipe settle
    // (skipped beats may still be in flight) before touching the registers
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Whole frames only: the line store is then always filled by an even row
    // before the odd row reads it, and positions are back at the origin.
    task automatic send_frames(input int unsigned count, input bit burst, input int hold);
        rbd_pkg::pixel_t px;
        for (int i = 0; i < count; i++) begin
            if (i == hold) begin
                // sender pauses until everything owed has come out
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (sb.pending_count() != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 15) == 0)
                px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                px = 16'($urandom_range(0, 16'hFFFF));
            send_pixel(px, draw_gap(burst));
        end
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = rbd_pkg::CFG_SOURCE_WIDTH;
        cfg_wr_data   = '0;
        sink_no_stall = 1'b0;

        // 4x5 frame: rows 0..3 make two output rows, row 4 is skipped,
        // columns 2..3 are skipped. Channel extremes in the first block.
        directed_pixels = '{
            16'hFFFF, 16'hFFFF, 16'h1234, 16'hABCD,
            16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA,
            16'hF800, 16'h07E0, 16'h0000, 16'hFFFF,
            16'h001F, 16'h0001, 16'h8000, 16'h7FFF,
            16'h0821, 16'hFFFE, 16'h0000, 16'hFFFF
        };

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: output width 0 acts as 1, output height 9 saturates to 2
        apply_sizes(11'd4, 11'd5, 10'd0, 10'd9);
        foreach (directed_pixels[i])
            send_pixel(directed_pixels[i], draw_gap(1'b0));
        drain();

        // random phases; phase 3 is a single maximum-size frame, either the
        // widest rows at minimum height or the tallest frame at minimum width
        phase_no    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            phase_no++;
            if (phase_no == 3) begin
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 2))
                        0: sw_raw = 11'd1024;
                        1: sw_raw = 11'd2047;
                        default: sw_raw = 11'd1500;
                    endcase
                    sh_raw = 11'($urandom_range(0, 2));
                    ow_raw = $urandom_range(0, 1) ? 10'd512 : 10'd1023;
                    oh_raw = 10'($urandom_range(0, 1));
                end else begin
                    sw_raw = 11'($urandom_range(0, 2));
                    sh_raw = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
                    ow_raw = 10'($urandom_range(0, 1));
                    oh_raw = $urandom_range(0, 1) ? 10'd512 : 10'd1023;
                end
                frames = 1;
            end else begin
                sw_raw = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 1))
                                                     : 11'($urandom_range(2, 16));
                sh_raw = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 1))
                                                     : 11'($urandom_range(2, 12));
                ow_raw = 10'($urandom_range(0, 10));
                oh_raw = 10'($urandom_range(0, 8));
                frames = $urandom_range(1, 3);
            end
            apply_sizes(sw_raw, sh_raw, ow_raw, oh_raw);

            pix_total     = frames * sb.frame_pixel_count();
            src_burst     = ($urandom_range(0, 3) == 0);
            sink_no_stall = ($urandom_range(0, 3) == 0);
            if (phase_no == 1 || $urandom_range(0, 3) == 0)
                hold_at = $urandom_range(0, pix_total - 1);
            else
                hold_at = -1;

            send_frames(pix_total, src_burst, hold_at);
            random_sent += pix_total;
            drain();
        end

        repeat (8) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending_count() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
